### hw/rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies; imported by i2cm_front, i2cm_queue, i2cm_back and the top level.
package i2cm_pkg;

    localparam int unsigned CMD_W     = 3;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TIMEOUT_W = 16;

    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 16'd500;

    // Raw command codes on the request channel
    localparam logic [CMD_W-1:0] CMD_CODE_NONE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CODE_START     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CODE_WRITE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CODE_READ_ACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CODE_READ_NACK = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CODE_STOP      = 3'd5;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_WRITE,
        CMD_READ_ACK,
        CMD_READ_NACK,
        CMD_STOP
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_S1,
        PH_S2,
        PH_WHIGH,
        PH_WLOW,
        PH_ALOW,
        PH_AHIGH,
        PH_APOLL,
        PH_RHIGH,
        PH_RLOW,
        PH_KHIGH,
        PH_KEND,
        PH_P1,
        PH_P2,
        PH_P3
    } phase_t;

    typedef struct packed {
        cmd_t              kind;
        logic [BYTE_W-1:0] write_byte;
        logic              sda_level;
    } tick_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### hw/rtl/i2cm_if.sv
// Valid/ready channel interfaces for the I2C master byte engine.
// No dependencies.
interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] write_byte;
    logic       sda_level;

    modport source (output valid, output cmd, output write_byte, output sda_level,
                    input ready);
    modport sink   (input valid, input cmd, input write_byte, input sda_level,
                    output ready);
endinterface

interface i2cm_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       status;

    modport source (output valid, output scl_level, output sda_release, output busy_res,
                    output done_res, output read_byte, output status, input ready);
    modport sink   (input valid, input scl_level, input sda_release, input busy_res,
                    input done_res, input read_byte, input status, output ready);
endinterface

### hw/rtl/i2cm_front.sv
// Request front end: accepts tick transactions and classifies the command code.
// Depends on i2cm_pkg and i2cm_req_if.
module i2cm_front
    import i2cm_pkg::*;
(
    i2cm_req_if.sink  req,
    input  q_stat_t   q_stat,
    output logic      push,
    output tick_t     push_item
);

    cmd_t kind;

    always_comb
    begin
        unique case (req.cmd)
            CMD_CODE_START:     kind = CMD_START;
            CMD_CODE_WRITE:     kind = CMD_WRITE;
            CMD_CODE_READ_ACK:  kind = CMD_READ_ACK;
            CMD_CODE_READ_NACK: kind = CMD_READ_NACK;
            CMD_CODE_STOP:      kind = CMD_STOP;
            default:            kind = CMD_NONE;
        endcase
    end

    assign req.ready            = !q_stat.full;
    assign push                 = req.valid && !q_stat.full;
    assign push_item.kind       = kind;
    assign push_item.write_byte = req.write_byte;
    assign push_item.sda_level  = req.sda_level;

endmodule

### hw/rtl/i2cm_queue.sv
// Short FIFO of classified ticks between front end and engine.
// Depends on i2cm_pkg.
module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  tick_t   push_item,
    input  logic    pop,
    output tick_t   pop_item,
    output q_stat_t q_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tick_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item     = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);

endmodule

### hw/rtl/i2cm_back.sv
// Bus engine: steps the SCL/SDA sequencer once per queued tick and holds
// the result in an output register. Depends on i2cm_pkg and i2cm_rsp_if.
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TIMEOUT_W-1:0] cfg_wdata,
    input  q_stat_t              q_stat,
    input  tick_t                item,
    output logic                 pop,
    i2cm_rsp_if.source           rsp
);

    logic [TIMEOUT_W-1:0] ack_timeout_reg;

    phase_t               phase_reg, phase_next;
    cmd_t                 active_reg, active_next;
    logic [2:0]           bit_reg, bit_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [TIMEOUT_W-1:0] wait_reg, wait_next, wait_dec;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic [BYTE_W-1:0]    last_read_reg, last_read_next;
    logic                 done, status;

    logic                 valid_reg;
    logic                 out_scl_reg, out_sda_reg, out_busy_reg, out_done_reg, out_status_reg;
    logic [BYTE_W-1:0]    out_read_reg;

    assign pop      = !q_stat.empty && (!valid_reg || rsp.ready);
    assign wait_dec = wait_reg - 1'b1;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                unique case (item.kind)
                    CMD_START:     phase_next = PH_S1;
                    CMD_WRITE:     phase_next = PH_WHIGH;
                    CMD_STOP:      phase_next = PH_P1;
                    CMD_READ_ACK,
                    CMD_READ_NACK: phase_next = PH_RHIGH;
                    default:       phase_next = PH_IDLE;
                endcase
            end
            PH_S1:    phase_next = PH_S2;
            PH_S2:    phase_next = PH_IDLE;
            PH_WHIGH: phase_next = (bit_reg == 3'd7) ? PH_ALOW : PH_WLOW;
            PH_WLOW:  phase_next = PH_WHIGH;
            PH_ALOW:  phase_next = PH_AHIGH;
            PH_AHIGH: phase_next = PH_APOLL;
            PH_APOLL:
            begin
                priority if (!item.sda_level)
                begin
                    phase_next = PH_IDLE;
                end
                else if (wait_dec == '0)
                begin
                    phase_next = PH_P1;
                end
                else
                begin
                    phase_next = PH_APOLL;
                end
            end
            PH_RHIGH: phase_next = PH_RLOW;
            PH_RLOW:  phase_next = (bit_reg == 3'd7) ? PH_KHIGH : PH_RHIGH;
            PH_KHIGH: phase_next = PH_KEND;
            PH_KEND:  phase_next = PH_IDLE;
            PH_P1:    phase_next = PH_P2;
            PH_P2:    phase_next = PH_P3;
            PH_P3:    phase_next = PH_IDLE;
            default:  phase_next = PH_IDLE;
        endcase
    end

    // line drive and datapath
    always_comb
    begin
        active_next    = active_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        wait_next      = wait_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;
        status         = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.kind != CMD_NONE)
                begin
                    active_next = item.kind;
                    bit_next    = '0;
                end
                unique case (item.kind)
                    CMD_START:
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    CMD_WRITE:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = item.write_byte[BYTE_W-1];
                        shift_next = {item.write_byte[BYTE_W-2:0], 1'b0};
                    end
                    CMD_STOP:
                    begin
                        scl_next = 1'b0;
                    end
                    CMD_READ_ACK,
                    CMD_READ_NACK:
                    begin
                        shift_next = '0;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                    end
                    default:
                    begin
                        scl_next = scl_reg;
                    end
                endcase
            end
            PH_S1: sda_next = 1'b0;
            PH_S2:
            begin
                scl_next = 1'b0;
                done     = 1'b1;
            end
            PH_WHIGH:
            begin
                scl_next = 1'b1;
                if (bit_reg != 3'd7)
                begin
                    bit_next = bit_reg + 1'b1;
                end
            end
            PH_WLOW:
            begin
                scl_next   = 1'b0;
                sda_next   = shift_reg[BYTE_W-1];
                shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
            end
            PH_ALOW:
            begin
                scl_next = 1'b0;
                sda_next = 1'b1;
            end
            PH_AHIGH:
            begin
                scl_next  = 1'b1;
                wait_next = (ack_timeout_reg == '0) ? TIMEOUT_W'(1) : ack_timeout_reg;
            end
            PH_APOLL:
            begin
                if (!item.sda_level)
                begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
                else
                begin
                    wait_next = wait_dec;
                    if (wait_dec == '0)
                    begin
                        scl_next = 1'b0;
                    end
                end
            end
            PH_RHIGH: scl_next = 1'b1;
            PH_RLOW:
            begin
                shift_next = {shift_reg[BYTE_W-2:0], item.sda_level};
                scl_next   = 1'b0;
                if (bit_reg == 3'd7)
                begin
                    sda_next = (active_reg != CMD_READ_ACK);
                end
                else
                begin
                    bit_next = bit_reg + 1'b1;
                end
            end
            PH_KHIGH: scl_next = 1'b1;
            PH_KEND:
            begin
                scl_next       = 1'b0;
                last_read_next = shift_reg;
                done           = 1'b1;
            end
            PH_P1: sda_next = 1'b0;
            PH_P2: scl_next = 1'b1;
            PH_P3:
            begin
                sda_next = 1'b1;
                done     = 1'b1;
                status   = (active_reg == CMD_WRITE);
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            ack_timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            active_reg    <= CMD_NONE;
            bit_reg       <= '0;
            shift_reg     <= '0;
            wait_reg      <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            last_read_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg     <= phase_next;
                active_reg    <= active_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                wait_reg      <= wait_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                last_read_reg <= last_read_next;
                valid_reg     <= 1'b1;
            end
            else if (rsp.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_scl_reg    <= scl_next;
            out_sda_reg    <= sda_next;
            out_busy_reg   <= (phase_next != PH_IDLE);
            out_done_reg   <= done;
            out_read_reg   <= last_read_next;
            out_status_reg <= status;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.scl_level   = out_scl_reg;
    assign rsp.sda_release = out_sda_reg;
    assign rsp.busy_res    = out_busy_reg;
    assign rsp.done_res    = out_done_reg;
    assign rsp.read_byte   = out_read_reg;
    assign rsp.status      = out_status_reg;

endmodule

### hw/rtl/i2c_master_byte_engine_top.sv
// Top level of the I2C master byte engine: front end, tick queue, bus engine.
// Depends on i2cm_pkg, i2cm_if, i2cm_front, i2cm_queue and i2cm_back.
//
//  port   | direction | handshake        | payload
//  -------+-----------+------------------+-------------------------------------------
//  req    | in        | valid/ready      | cmd, write_byte, sda_level
//  rsp    | out       | valid/ready      | scl_level, sda_release, busy_res, done_res,
//         |           |                  | read_byte, status
//  cfg    | in        | cfg_we           | cfg_wdata = ack_timeout
//
//  One transaction in gives one transaction out; one tick per clock sustained while
//  rsp.ready holds. A tick is written into the queue when accepted, and the engine
//  then steps it into the output register.
//  The engine steps only when the output register is free or being drained.
//  req.ready drops once the queue holds QUEUE_DEPTH ticks behind a stalled rsp.
//  Async reset: lines released, engine idle, ack_timeout 500, queue empty.
module i2c_master_byte_engine_top
    import i2cm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TIMEOUT_W-1:0] cfg_wdata,
    i2cm_req_if.sink             req,
    i2cm_rsp_if.source           rsp
);

    q_stat_t q_stat;
    logic    push, pop;
    tick_t   push_item, pop_item;

    i2cm_front u_front
    (
        .req       (req),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    i2cm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .item      (pop_item),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

### hw/rtl/i2cm_checker.sv
// Port-level checker for the I2C master byte engine, bound to the top level.
// Depends on i2c_master_byte_engine_top port names.
module i2cm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       scl_level,
    input logic       sda_release,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] read_byte,
    input logic       status
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({scl_level, sda_release,
            busy_res, done_res, read_byte, status}))
        else $error("rsp payload changed while stalled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    a_fail_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> done_res && scl_level && sda_release)
        else $error("timeout reported without completed stop");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("rsp valid right after reset");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .scl_level   (rsp.scl_level),
    .sda_release (rsp.sda_release),
    .busy_res    (rsp.busy_res),
    .done_res    (rsp.done_res),
    .read_byte   (rsp.read_byte),
    .status      (rsp.status)
);

### sim/tb_i2c_master_byte_engine_top.sv
// Testbench for i2c_master_byte_engine_top: a queue-fed driver, a checking monitor,
// and a tick-level model of the I2C bus engine that predicts every response.
// Depends on i2cm_pkg, i2cm_if and the RTL of the block.
module tb_i2c_master_byte_engine_top;
    import i2cm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_CODE_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_CODE_RSVD7 = 3'd7;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int PHASE_TICKS     = 316;
    localparam int HOLD_CYCLES     = 80;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] wbyte;
        logic              sda;
    } bus_tick_t;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rd_byte;
        logic              status;
    } line_rsp_t;

    typedef struct {
        phase_t               phase;
        logic [CMD_W-1:0]     active_cmd;
        logic [2:0]           bit_cnt;
        logic [BYTE_W-1:0]    shifter;
        logic [TIMEOUT_W-1:0] wait_cnt;
        logic                 scl;
        logic                 sda;
        logic [BYTE_W-1:0]    last_rd;
        logic [TIMEOUT_W-1:0] ack_timeout;
    } bus_state_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [TIMEOUT_W-1:0] cfg_wdata;
    logic                 hold_rsp;
    logic                 hold_go;

    i2cm_req_if req_if();
    i2cm_rsp_if rsp_if();

    bus_tick_t  pending_q[$];
    line_rsp_t  expected_q[$];
    bus_state_t model;
    bus_state_t gen;
    line_rsp_t  gen_last;
    int         counted;
    int         err_cnt;
    int         send_idle_pct;
    int         recv_idle_pct;

    i2c_master_byte_engine_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void bus_reset(output bus_state_t s);
        s.phase       = PH_IDLE;
        s.active_cmd  = CMD_CODE_NONE;
        s.bit_cnt     = '0;
        s.shifter     = '0;
        s.wait_cnt    = '0;
        s.scl         = 1'b1;
        s.sda         = 1'b1;
        s.last_rd     = '0;
        s.ack_timeout = ACK_TIMEOUT_RST;
    endfunction

    function automatic void bus_step(inout bus_state_t s, input bus_tick_t t,
                                     output line_rsp_t r);
        logic done;
        logic stat;
        done = 1'b0;
        stat = 1'b0;
        case (s.phase)
            PH_IDLE:
            begin
                if (t.cmd >= CMD_CODE_START && t.cmd <= CMD_CODE_STOP)
                begin
                    s.active_cmd = t.cmd;
                    s.bit_cnt    = '0;
                    if (t.cmd == CMD_CODE_START)
                    begin
                        s.sda   = 1'b1;
                        s.scl   = 1'b1;
                        s.phase = PH_S1;
                    end
                    else if (t.cmd == CMD_CODE_WRITE)
                    begin
                        s.scl     = 1'b0;
                        s.sda     = t.wbyte[7];
                        s.shifter = {t.wbyte[6:0], 1'b0};
                        s.phase   = PH_WHIGH;
                    end
                    else if (t.cmd == CMD_CODE_STOP)
                    begin
                        s.scl   = 1'b0;
                        s.phase = PH_P1;
                    end
                    else
                    begin
                        s.shifter = '0;
                        s.scl     = 1'b0;
                        s.sda     = 1'b1;
                        s.phase   = PH_RHIGH;
                    end
                end
            end
            PH_S1:
            begin
                s.sda   = 1'b0;
                s.phase = PH_S2;
            end
            PH_S2:
            begin
                s.scl   = 1'b0;
                done    = 1'b1;
                s.phase = PH_IDLE;
            end
            PH_WHIGH:
            begin
                s.scl = 1'b1;
                if (s.bit_cnt == 3'd7)
                    s.phase = PH_ALOW;
                else
                begin
                    s.bit_cnt = s.bit_cnt + 3'd1;
                    s.phase   = PH_WLOW;
                end
            end
            PH_WLOW:
            begin
                s.scl     = 1'b0;
                s.sda     = s.shifter[7];
                s.shifter = {s.shifter[6:0], 1'b0};
                s.phase   = PH_WHIGH;
            end
            PH_ALOW:
            begin
                s.scl   = 1'b0;
                s.sda   = 1'b1;
                s.phase = PH_AHIGH;
            end
            PH_AHIGH:
            begin
                s.scl      = 1'b1;
                s.wait_cnt = (s.ack_timeout == '0) ? 16'd1 : s.ack_timeout;
                s.phase    = PH_APOLL;
            end
            PH_APOLL:
            begin
                if (!t.sda)
                begin
                    s.scl   = 1'b0;
                    done    = 1'b1;
                    s.phase = PH_IDLE;
                end
                else
                begin
                    s.wait_cnt = s.wait_cnt - 16'd1;
                    if (s.wait_cnt == '0)
                    begin
                        s.scl   = 1'b0;
                        s.phase = PH_P1;
                    end
                end
            end
            PH_RHIGH:
            begin
                s.scl   = 1'b1;
                s.phase = PH_RLOW;
            end
            PH_RLOW:
            begin
                s.shifter = {s.shifter[6:0], t.sda};
                s.scl     = 1'b0;
                if (s.bit_cnt == 3'd7)
                begin
                    s.sda   = (s.active_cmd == CMD_CODE_READ_ACK) ? 1'b0 : 1'b1;
                    s.phase = PH_KHIGH;
                end
                else
                begin
                    s.bit_cnt = s.bit_cnt + 3'd1;
                    s.phase   = PH_RHIGH;
                end
            end
            PH_KHIGH:
            begin
                s.scl   = 1'b1;
                s.phase = PH_KEND;
            end
            PH_KEND:
            begin
                s.scl     = 1'b0;
                s.last_rd = s.shifter;
                done      = 1'b1;
                s.phase   = PH_IDLE;
            end
            PH_P1:
            begin
                s.sda   = 1'b0;
                s.phase = PH_P2;
            end
            PH_P2:
            begin
                s.scl   = 1'b1;
                s.phase = PH_P3;
            end
            PH_P3:
            begin
                s.sda   = 1'b1;
                done    = 1'b1;
                stat    = (s.active_cmd == CMD_CODE_WRITE);
                s.phase = PH_IDLE;
            end
            default:
                s.phase = PH_IDLE;
        endcase
        r.scl     = s.scl;
        r.sda     = s.sda;
        r.busy    = (s.phase != PH_IDLE);
        r.done    = done;
        r.rd_byte = s.last_rd;
        r.status  = stat;
    endfunction

    function automatic void check_field(input string fname, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // Stimulus generation: a private engine copy tells when the bus is idle.
    function automatic void push_tick(input bus_tick_t t);
        if (gen.phase != PH_IDLE || (t.cmd >= CMD_CODE_START && t.cmd <= CMD_CODE_STOP))
            counted++;
        bus_step(gen, t, gen_last);
        pending_q.push_back(t);
    endfunction

    function automatic void idle_ticks(input int n);
        bus_tick_t t;
        int        sel;
        for (int i = 0; i < n; i++)
        begin
            sel     = $urandom_range(2);
            t.cmd   = (sel == 0) ? CMD_CODE_NONE : (sel == 1) ? CMD_CODE_RSVD6 : CMD_CODE_RSVD7;
            t.wbyte = BYTE_W'($urandom);
            t.sda   = 1'($urandom_range(1));
            push_tick(t);
        end
    endfunction

    function automatic void issue(input logic [CMD_W-1:0] cmd, input logic [7:0] wbyte);
        bus_tick_t t;
        int        eff;
        int        ack_after;
        int        polls;
        logic      never_ack;
        eff       = (gen.ack_timeout == '0) ? 1 : int'(gen.ack_timeout);
        never_ack = (eff <= 64) && ($urandom_range(99) < 25);
        ack_after = $urandom_range(0, (eff < 9) ? eff : 9);
        polls     = 0;
        t.cmd     = cmd;
        t.wbyte   = wbyte;
        t.sda     = 1'($urandom_range(1));
        push_tick(t);
        while (gen.phase != PH_IDLE)
        begin
            t.cmd   = ($urandom_range(99) < 20) ? CMD_W'($urandom_range(7)) : CMD_CODE_NONE;
            t.wbyte = BYTE_W'($urandom);
            t.sda   = 1'($urandom_range(1));
            if (gen.phase == PH_APOLL)
            begin
                t.sda = never_ack || (polls < ack_after);
                polls++;
            end
            push_tick(t);
        end
    endfunction

    function automatic void gen_sequence();
        int  n;
        if ($urandom_range(99) < 15)
        begin
            if ($urandom_range(1))
                issue(CMD_W'($urandom_range(CMD_CODE_START, CMD_CODE_STOP)),
                      BYTE_W'($urandom));
            else
                idle_ticks($urandom_range(1, 3));
            return;
        end
        issue(CMD_CODE_START, BYTE_W'($urandom));
        issue(CMD_CODE_WRITE, BYTE_W'($urandom));
        if (!gen_last.status)
        begin
            n = $urandom_range(1, 3);
            if ($urandom_range(1))
            begin
                for (int i = 0; i < n; i++)
                begin
                    issue(CMD_CODE_WRITE, BYTE_W'($urandom));
                    if (gen_last.status)
                        break;
                    idle_ticks($urandom_range(0, 1));
                end
            end
            else
            begin
                for (int i = 0; i < n; i++)
                    issue((i == n - 1) ? CMD_CODE_READ_NACK : CMD_CODE_READ_ACK,
                          BYTE_W'($urandom));
            end
            if (!gen_last.status)
                issue(CMD_CODE_STOP, BYTE_W'($urandom));
        end
        idle_ticks($urandom_range(0, 2));
    endfunction

    task automatic random_phase(input int n);
        @(negedge clk);
        counted = 0;
        while (counted < n)
            gen_sequence();
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        cfg_we            <= 1'b1;
        cfg_wdata         <= value;
        model.ack_timeout  = value;
        gen.ack_timeout    = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin : drv_proc
        line_rsp_t pred;
        if (!rst_n)
        begin
            req_if.valid      <= 1'b0;
            req_if.cmd        <= CMD_CODE_NONE;
            req_if.write_byte <= '0;
            req_if.sda_level  <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                bus_step(model, pending_q.pop_front(), pred);
                expected_q.push_back(pred);
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_if.valid      <= 1'b1;
                    req_if.cmd        <= pending_q[0].cmd;
                    req_if.write_byte <= pending_q[0].wbyte;
                    req_if.sda_level  <= pending_q[0].sda;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Monitor and response-side flow control
    always @(posedge clk or negedge rst_n)
    begin : mon_proc
        line_rsp_t exp_r;
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none actual scl %0b sda %0b",
                             $time, rsp_if.scl_level, rsp_if.sda_release);
                    err_cnt++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    check_field("scl_level", exp_r.scl, rsp_if.scl_level);
                    check_field("sda_release", exp_r.sda, rsp_if.sda_release);
                    check_field("busy_res", exp_r.busy, rsp_if.busy_res);
                    check_field("done_res", exp_r.done, rsp_if.done_res);
                    check_field("read_byte", exp_r.rd_byte, rsp_if.read_byte);
                    check_field("status", exp_r.status, rsp_if.status);
                end
            end
            rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off to back the block up
    initial
    begin
        hold_rsp = 1'b0;
        wait (hold_go === 1'b1);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        bus_tick_t t;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        hold_go       = 1'b0;
        err_cnt       = 0;
        counted       = 0;
        send_idle_pct = 14;
        recv_idle_pct = 55;
        bus_reset(model);
        bus_reset(gen);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reserved and empty commands, every operation, byte extremes
        @(negedge clk);
        t.wbyte = 8'hFF;
        t.sda   = 1'b1;
        t.cmd   = CMD_CODE_NONE;
        push_tick(t);
        t.cmd   = CMD_CODE_RSVD6;
        push_tick(t);
        t.cmd   = CMD_CODE_RSVD7;
        t.sda   = 1'b0;
        push_tick(t);
        issue(CMD_CODE_START, 8'h00);
        issue(CMD_CODE_WRITE, 8'hFF);
        issue(CMD_CODE_WRITE, 8'h00);
        issue(CMD_CODE_READ_ACK, 8'hFF);
        issue(CMD_CODE_READ_NACK, 8'h00);
        issue(CMD_CODE_STOP, 8'hFF);
        drain();

        write_timeout(16'd1);
        random_phase(PHASE_TICKS);
        drain();

        send_idle_pct = 55;
        recv_idle_pct = 14;
        write_timeout(16'd0);
        random_phase(PHASE_TICKS);
        drain();

        write_timeout(16'hFFFF);
        random_phase(PHASE_TICKS);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_timeout(16'd7);
        random_phase(PHASE_TICKS);
        hold_go = 1'b1;
        drain();

        write_timeout(TIMEOUT_W'($urandom_range(2, 40)));
        random_phase(PHASE_TICKS);
        drain();
        repeat (8) @(posedge clk);

        if (err_cnt == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
